### design/dmx_pkg.sv
// Shared types and constants for the distributed mutex node.
// Holds opcode and message codes, sequencer states and the result word layout.
// Depends on nothing; every other design file imports it.
package dmx_pkg;

	// Fixed field widths of the ports.
	localparam int ID_W      = 5;
	localparam int OP_W      = 2;
	localparam int KIND_W    = 2;
	localparam int PSEQ_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_NODES = 16;
	localparam int DEF_SEQ_BITS  = 16;

	// Configuration register indexes and their reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 1'd1;
	localparam logic [ID_W-1:0]      OWN_ID_RESET     = 5'd1;
	localparam logic [ID_W-1:0]      NODE_TOTAL_RESET = 5'd2;

	// Input event codes.
	typedef enum logic [OP_W-1:0] {
		OP_LOCAL_REQ  = 2'd0,
		OP_PEER_REQ   = 2'd1,
		OP_PEER_REPLY = 2'd2,
		OP_RELEASE    = 2'd3
	} op_t;

	// Outgoing message codes.
	typedef enum logic [KIND_W-1:0] {
		MSG_REQUEST = 2'd0,
		MSG_REPLY   = 2'd1,
		MSG_GRANT   = 2'd2
	} msg_kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EMIT,
		ST_REQ_SCAN,
		ST_REL_FIND,
		ST_REL_SEND
	} state_t;

	// One result word as it travels to the output register.
	typedef struct packed {
		msg_kind_t         kind;
		logic [ID_W-1:0]   dest;
		logic [PSEQ_W-1:0] seq;
		logic              last;
	} result_t;

endpackage

### design/dmx_out_reg.sv
// Output register of the distributed mutex node.
// Holds one result word and parts the sequencer from the downstream ready.
// Depends on dmx_pkg for the result word layout.
module dmx_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmx_pkg::result_t push_data,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output dmx_pkg::result_t out_data
);
	import dmx_pkg::*;

	logic    valid_q;
	result_t data_q;

	// A new word may enter when the register is empty or is being emptied.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// The valid flag is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= push || (valid_q && !out_ready);
		end
	end

	// The word itself needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

### design/distributed_mutex_node_unit.sv
// One node of Ricart-Agrawala distributed mutual exclusion. Each accepted word
// is latched, decided in the dispatch state, and any results leave through a
// one-word output register. An incoming request, reply or a stray event
// produces at most a single result. A local request scans the node ids from 1
// up to the highest id that receives a request (n, or n - 1 when this node
// holds id n, where n is the active node count), emitting one request per peer;
// with no peers it grants at once. A release scans ids 1 to n to find the last
// deferred peer, then scans again up to that peer to send the replies. The
// shared node-id scan counter visits one id a cycle, and holds while a result
// word waits for downstream ready.
// Configuration writes take effect at once and leave the node state untouched.
module distributed_mutex_node_unit #(
	parameter int MAX_NODES = dmx_pkg::DEF_MAX_NODES,
	parameter int SEQ_BITS  = dmx_pkg::DEF_SEQ_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dmx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dmx_pkg::ID_W-1:0]       cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dmx_pkg::OP_W-1:0]       opcode,
	input  logic [dmx_pkg::ID_W-1:0]       peer_id,
	input  logic [dmx_pkg::PSEQ_W-1:0]     peer_seq,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dmx_pkg::KIND_W-1:0]     msg_kind,
	output logic [dmx_pkg::ID_W-1:0]       dest_node,
	output logic [dmx_pkg::PSEQ_W-1:0]     msg_seq,
	output logic                           last_of_run
);
	import dmx_pkg::*;

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int PEND_W = IDX_W;
	localparam int XW     = (ID_W > IDX_W) ? ID_W : IDX_W;
	localparam int SW     = (PSEQ_W > SEQ_BITS) ? PSEQ_W : SEQ_BITS;

	// Map a node id onto its slot in the deferred mask.
	function automatic logic [IDX_W-1:0] slot(input logic [ID_W-1:0] id);
		logic [XW-1:0] w;
		w = XW'(id) - XW'(1);
		return w[IDX_W-1:0];
	endfunction

	// Configuration registers.
	logic [ID_W-1:0] own_id_q;
	logic [ID_W-1:0] node_total_q;

	// Node state.
	logic [SEQ_BITS-1:0]  own_seq_q;
	logic [SEQ_BITS-1:0]  highest_q;
	logic [PEND_W-1:0]    pending_q;
	logic                 requesting_q;
	logic [MAX_NODES-1:0] mask_q;

	// Sequencer, scan counter and the latched input word.
	state_t              state_q;
	state_t              state_d;
	logic [ID_W-1:0]     j_q;
	logic [ID_W-1:0]     last_q;
	op_t                 op_q;
	logic [ID_W-1:0]     pid_q;
	logic [SEQ_BITS-1:0] pseq_q;

	// Derived values.
	logic [ID_W-1:0]     n_w;
	logic [ID_W-1:0]     last_req;
	logic                pid_valid;
	logic                own_valid;
	logic                defer;
	logic                j_valid;
	logic                hit;
	logic                scan_end;
	logic [SEQ_BITS-1:0] next_own_seq;
	logic [SEQ_BITS-1:0] pseq_in;
	logic [SW-1:0]       pseq_wide;
	logic [SW-1:0]       own_wide;

	// Output path.
	logic    want;
	logic    push;
	logic    can_load;
	result_t res;
	result_t out_data;

	// Active node count is the configured total capped at the mask size.
	assign n_w = (32'(node_total_q) < 32'(MAX_NODES)) ? node_total_q : ID_W'(MAX_NODES);

	// Peer checks and the highest id that receives a request.
	assign pid_valid = (pid_q != '0) && (pid_q <= n_w) && (pid_q != own_id_q);
	assign own_valid = (own_id_q != '0) && (own_id_q <= n_w);
	assign last_req  = (own_id_q == n_w) ? (n_w - ID_W'(1)) : n_w;

	// Ordering of an incoming request against this node's own pair.
	assign defer = requesting_q && ((pseq_q > own_seq_q) ||
		((pseq_q == own_seq_q) && (pid_q > own_id_q)));

	// Sequence numbers saturate at their maximum.
	assign next_own_seq = (highest_q == '1) ? highest_q : (highest_q + SEQ_BITS'(1));

	// Width conversions between the ports and the internal sequence width.
	assign pseq_wide = SW'(peer_seq);
	assign pseq_in   = pseq_wide[SEQ_BITS-1:0];
	assign own_wide  = SW'(own_seq_q);

	// Scan counter checks: a valid peer id and a deferred entry under it.
	assign j_valid  = (j_q <= n_w) && (j_q != own_id_q);
	assign hit      = j_valid && mask_q[slot(j_q)];
	assign scan_end = (j_q >= n_w);

	assign in_ready = (state_q == ST_IDLE);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (op_q)
					OP_LOCAL_REQ: begin
						if (!requesting_q && own_valid) begin
							state_d = (n_w == ID_W'(1)) ? ST_EMIT : ST_REQ_SCAN;
						end
					end
					OP_PEER_REQ: begin
						if (pid_valid && !defer) begin
							state_d = ST_EMIT;
						end
					end
					OP_PEER_REPLY: begin
						if (pid_valid && requesting_q && (pending_q == PEND_W'(1))) begin
							state_d = ST_EMIT;
						end
					end
					OP_RELEASE: begin
						if (requesting_q && (pending_q == '0)) begin
							state_d = ST_REL_FIND;
						end
					end
				endcase
			end
			ST_EMIT: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_REQ_SCAN: begin
				if (want && can_load && (j_q == last_req)) begin
					state_d = ST_IDLE;
				end
			end
			ST_REL_FIND: begin
				if (scan_end) begin
					state_d = (hit || (last_q != '0)) ? ST_REL_SEND : ST_IDLE;
				end
			end
			ST_REL_SEND: begin
				if (hit && can_load && (j_q == last_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result word offered to the output register in each state.
	always_comb begin
		want     = 1'b0;
		res.kind = MSG_GRANT;
		res.dest = '0;
		res.seq  = '0;
		res.last = 1'b1;
		unique case (state_q)
			ST_EMIT: begin
				want = 1'b1;
				if (op_q == OP_PEER_REQ) begin
					res.kind = MSG_REPLY;
					res.dest = pid_q;
				end
			end
			ST_REQ_SCAN: begin
				want     = (j_q != own_id_q);
				res.kind = MSG_REQUEST;
				res.dest = j_q;
				res.seq  = own_wide[PSEQ_W-1:0];
				res.last = (j_q == last_req);
			end
			ST_REL_SEND: begin
				want     = hit;
				res.kind = MSG_REPLY;
				res.dest = j_q;
				res.last = (j_q == last_q);
			end
			ST_IDLE, ST_DISPATCH, ST_REL_FIND: begin
				want = 1'b0;
			end
			default: want = 1'b0;
		endcase
	end

	assign push = want && can_load;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= OWN_ID_RESET;
			node_total_q <= NODE_TOTAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_ID:     own_id_q     <= cfg_data;
				CFG_NODE_TOTAL: node_total_q <= cfg_data;
			endcase
		end
	end

	// Latch the input word when it is accepted.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= op_t'(opcode);
			pid_q  <= peer_id;
			pseq_q <= pseq_in;
		end
	end

	// Sequencer state, scan counter and node state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			j_q          <= '0;
			last_q       <= '0;
			own_seq_q    <= '0;
			highest_q    <= '0;
			pending_q    <= '0;
			requesting_q <= 1'b0;
			mask_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DISPATCH: begin
					unique case (op_q)
						OP_LOCAL_REQ: begin
							if (!requesting_q && own_valid) begin
								own_seq_q    <= next_own_seq;
								requesting_q <= 1'b1;
								pending_q    <= PEND_W'(n_w - ID_W'(1));
								j_q          <= ID_W'(1);
							end
						end
						OP_PEER_REQ: begin
							if (pid_valid) begin
								if (pseq_q > highest_q) begin
									highest_q <= pseq_q;
								end
								if (defer) begin
									mask_q[slot(pid_q)] <= 1'b1;
								end
							end
						end
						OP_PEER_REPLY: begin
							if (pid_valid && requesting_q && (pending_q != '0)) begin
								pending_q <= pending_q - PEND_W'(1);
							end
						end
						OP_RELEASE: begin
							if (requesting_q && (pending_q == '0)) begin
								requesting_q <= 1'b0;
								j_q          <= ID_W'(1);
								last_q       <= '0;
							end
						end
					endcase
				end
				ST_REQ_SCAN: begin
					if (!want || can_load) begin
						j_q <= j_q + ID_W'(1);
					end
				end
				ST_REL_FIND: begin
					if (hit) begin
						last_q <= j_q;
					end
					if (scan_end) begin
						j_q <= ID_W'(1);
						if (!hit && (last_q == '0)) begin
							mask_q <= '0;
						end
					end else begin
						j_q <= j_q + ID_W'(1);
					end
				end
				ST_REL_SEND: begin
					if (!hit || can_load) begin
						if (hit && (j_q == last_q)) begin
							mask_q <= '0;
						end else begin
							j_q <= j_q + ID_W'(1);
						end
					end
				end
				ST_IDLE, ST_EMIT: begin
					j_q <= j_q;
				end
				default: j_q <= j_q;
			endcase
		end
	end

	// Output register and port fields.
	dmx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign msg_kind    = out_data.kind;
	assign dest_node   = out_data.dest;
	assign msg_seq     = out_data.seq;
	assign last_of_run = out_data.last;

`ifndef SYNTH
	// Outstanding replies exist only while this node is requesting.
	a_pend_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) |-> requesting_q)
		else $error("replies pending while not requesting");

	// The request scan stays within the ids that receive a request.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REQ_SCAN) |-> ((j_q != '0) && (j_q <= last_req)))
		else $error("request scan index out of range");

	// A grant leaves only once every reply has arrived.
	a_grant_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (res.kind == MSG_GRANT)) |-> (requesting_q && (pending_q == '0)))
		else $error("grant issued with replies outstanding");

	// The final deferred reply of a release empties the deferred mask.
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_REL_SEND) && push && res.last) |=> (mask_q == '0))
		else $error("deferred mask not cleared after release");
`endif

endmodule
